FILE: design/kac_pkg.sv
// Shared types, constants and codes for the knob angle to controller change block.
`timescale 1ns / 1ps
`default_nettype none
package kac_pkg;

  // Fixed field widths
  localparam int KNOB_BITS     = 5;
  localparam int ANGLE_BITS    = 12;
  localparam int FRAC_BITS     = 16;
  localparam int GAIN_BITS     = 16;
  localparam int DEAD_BITS     = 12;
  localparam int CC_BITS       = 7;
  localparam int DISP_BITS     = 23;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  // Derived arithmetic widths
  localparam int UP_SHIFT   = (FRAC_BITS > 16) ? (FRAC_BITS - 16) : 0;
  localparam int DOWN_SHIFT = (FRAC_BITS < 16) ? (16 - FRAC_BITS) : 0;
  localparam int PROD_W     = ANGLE_BITS + GAIN_BITS;
  localparam int MAG_W      = PROD_W + UP_SHIFT;
  localparam int KV_W       = CC_BITS + FRAC_BITS;
  localparam int ACC_W      = FRAC_BITS + 1;
  localparam int SUM_W      = ((MAG_W > KV_W) ? MAG_W : KV_W) + 2;
  localparam int STEP_W     = SUM_W - FRAC_BITS;

  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN_NORMAL = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN_DETENT = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DEAD_BAND   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DETENT_LOW  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DETENT_HIGH = 3'd4;

  localparam logic [GAIN_BITS-1:0] RST_GAIN_NORMAL = 16'd2032;
  localparam logic [GAIN_BITS-1:0] RST_GAIN_DETENT = 16'd813;
  localparam logic [DEAD_BITS-1:0] RST_DEAD_BAND   = 12'd3;
  localparam logic [CC_BITS-1:0]   RST_DETENT_LOW  = 7'd60;
  localparam logic [CC_BITS-1:0]   RST_DETENT_HIGH = 7'd68;

  // CC modes
  localparam logic [1:0] MODE_ABS        = 2'd0;
  localparam logic [1:0] MODE_REL_TWOS   = 2'd1;
  localparam logic [1:0] MODE_REL_OFFSET = 2'd2;

  // Item classes set by the front end
  localparam logic [1:0] KIND_SKIP = 2'd0;  // knob out of range
  localparam logic [1:0] KIND_HOLD = 2'd1;  // resync or override hold
  localparam logic [1:0] KIND_MOVE = 2'd2;  // regular angle sample

  typedef struct packed {
    logic [KNOB_BITS-1:0]  knob_index;
    logic [ANGLE_BITS-1:0] angle;
    logic                  resync;
    logic                  override_hold;
    logic [1:0]            cc_mode;
    logic                  center_detent;
  } in_t;

  typedef struct packed {
    logic [KNOB_BITS-1:0] out_knob;
    logic                 cc_valid;
    logic [CC_BITS-1:0]   cc_value;
    logic                 display_valid;
    logic [DISP_BITS-1:0] display_value;
  } out_t;

  typedef struct packed {
    logic [GAIN_BITS-1:0] gain_normal;
    logic [GAIN_BITS-1:0] gain_detent;
    logic [DEAD_BITS-1:0] dead_band;
    logic [CC_BITS-1:0]   detent_low;
    logic [CC_BITS-1:0]   detent_high;
  } cfg_t;

  typedef struct packed {
    logic [KNOB_BITS-1:0]  knob;
    logic [1:0]            kind;
    logic [ANGLE_BITS-1:0] angle;
    logic [1:0]            mode;
    logic                  detent;
    logic [GAIN_BITS-1:0]  gain;
  } q_ent_t;

  // Per-knob value state
  typedef struct packed {
    logic [KV_W-1:0]         kv;
    logic signed [ACC_W-1:0] acc;
    logic [CC_BITS-1:0]      sent;
  } val_ent_t;

endpackage
`default_nettype wire

FILE: design/kac_front.sv
// Front end: takes input transactions, classifies them and picks the gain.
`timescale 1ns / 1ps
`default_nettype none
module kac_front #(
  parameter int NUM_KNOBS = 20
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire kac_pkg::cfg_t   cfg,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire kac_pkg::in_t    in_data,
  input  wire logic            q_full,
  output logic                 q_push,
  output kac_pkg::q_ent_t      q_ent
);

  logic            f_v_r;
  logic            f_v_nxt;
  kac_pkg::q_ent_t f_ent_r;
  kac_pkg::q_ent_t f_ent_nxt;
  logic            take;

  assign q_push   = f_v_r && !q_full;
  assign in_ready = !f_v_r || !q_full;
  assign take     = in_valid && in_ready;
  assign q_ent    = f_ent_r;

  always_comb begin
    f_ent_nxt.knob   = in_data.knob_index;
    f_ent_nxt.angle  = in_data.angle;
    f_ent_nxt.mode   = in_data.cc_mode;
    f_ent_nxt.detent = in_data.center_detent;
    f_ent_nxt.gain   = in_data.center_detent ? cfg.gain_detent : cfg.gain_normal;
    priority if (32'(in_data.knob_index) >= NUM_KNOBS) begin
      f_ent_nxt.kind = kac_pkg::KIND_SKIP;
    end else if (in_data.resync || in_data.override_hold) begin
      f_ent_nxt.kind = kac_pkg::KIND_HOLD;
    end else begin
      f_ent_nxt.kind = kac_pkg::KIND_MOVE;
    end
    f_v_nxt = take || (f_v_r && q_full);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else begin
      f_v_r <= f_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      f_ent_r <= f_ent_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: design/kac_queue.sv
// Short queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module kac_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire kac_pkg::q_ent_t push_ent,
  output logic                 full,
  input  wire logic            pop,
  output logic                 q_valid,
  output kac_pkg::q_ent_t      q_ent
);

  localparam int QPW = (kac_pkg::QUEUE_DEPTH > 1) ? $clog2(kac_pkg::QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(kac_pkg::QUEUE_DEPTH + 1);
  localparam logic [QPW-1:0] LAST = QPW'(kac_pkg::QUEUE_DEPTH - 1);

  kac_pkg::q_ent_t ent_r [kac_pkg::QUEUE_DEPTH];
  logic [QPW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]  cnt_r, cnt_nxt;
  logic            do_push;
  logic            do_pop;

  assign full    = (cnt_r == QCW'(kac_pkg::QUEUE_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_ent   = ent_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_ent;
    end
  end

endmodule
`default_nettype wire

FILE: design/kac_back.sv
// Back end: per-knob state memories, read stage, angle/gain stage, value update stage, result register.
`timescale 1ns / 1ps
`default_nettype none
module kac_back #(
  parameter int NUM_KNOBS = 20
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire kac_pkg::cfg_t   cfg,
  input  wire logic            q_valid,
  input  wire kac_pkg::q_ent_t q_ent,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output kac_pkg::out_t        out_data
);

  localparam int KW     = (NUM_KNOBS > 1) ? $clog2(NUM_KNOBS) : 1;
  localparam int AB     = kac_pkg::ANGLE_BITS;
  localparam int FB     = kac_pkg::FRAC_BITS;
  localparam int DW     = AB + 2;
  localparam int MAG_W  = kac_pkg::MAG_W;
  localparam int KV_W   = kac_pkg::KV_W;
  localparam int ACC_W  = kac_pkg::ACC_W;
  localparam int SUM_W  = kac_pkg::SUM_W;
  localparam int STEP_W = kac_pkg::STEP_W;
  localparam int PROD_W = kac_pkg::PROD_W;
  localparam int CB     = kac_pkg::CC_BITS;

  localparam logic signed [DW-1:0]    HALF_TURN = DW'(1 << (AB - 1));
  localparam logic signed [DW-1:0]    FULL_TURN = DW'(1 << AB);
  localparam logic signed [SUM_W-1:0] MAX_V     = SUM_W'(127 * (1 << FB));
  localparam logic [KV_W-1:0]         CENTER_V  = KV_W'(64 * (1 << FB));

  // State memories
  logic [AB-1:0]         ang_mem [NUM_KNOBS];
  logic [NUM_KNOBS-1:0]  ang_vld_r;
  kac_pkg::val_ent_t     val_mem [NUM_KNOBS];
  logic [NUM_KNOBS-1:0]  val_vld_r;

  // Read stage
  logic                  pop;
  logic                  rd_en;
  logic [KW-1:0]         rd_addr;
  logic                  b_v_r;
  kac_pkg::q_ent_t       b_ent_r;
  logic [AB-1:0]         ang_rd_r;
  logic                  ang_rdv_r;
  kac_pkg::val_ent_t     val_rd_r;
  logic                  val_rdv_r;
  logic                  fwd_hit_r;
  kac_pkg::val_ent_t     fwd_r;

  // Angle and gain stage
  logic                  b_adv;
  logic [KW-1:0]         b_addr;
  logic [AB-1:0]         last_ang;
  logic signed [DW-1:0]  d_raw;
  logic signed [DW-1:0]  d_wrap;
  logic signed [DW-1:0]  d_abs;
  logic [AB-1:0]         absd;
  logic                  move_ok;
  logic                  ang_we;
  logic [PROD_W-1:0]     prod;
  logic [MAG_W-1:0]      mag;
  logic                  fwd_now;
  kac_pkg::val_ent_t     val_b;

  // Value stage
  logic                  c_v_r;
  logic [kac_pkg::KNOB_BITS-1:0] c_knob_r;
  logic                  c_act_r;
  logic [1:0]            c_mode_r;
  logic                  c_detent_r;
  logic                  c_neg_r;
  logic [MAG_W-1:0]      c_mag_r;
  kac_pkg::val_ent_t     c_val_r;
  logic                  c_adv;
  logic                  wr_en;
  logic [KW-1:0]         wr_addr;
  kac_pkg::val_ent_t     val_wr;

  logic signed [SUM_W-1:0] kv_s, mag_s, sc_s, vs, acc_s, acc_sum;
  logic [SUM_W-1:0]        acc_mag;
  logic                    acc_neg;
  logic [STEP_W-1:0]       stepm;
  logic [FB-1:0]           rem;
  logic signed [ACC_W-1:0] acc_new;
  logic                    gt64, gt63;
  logic [CB-1:0]           s7;
  logic [KV_W-1:0]         v_abs;
  logic [CB-1:0]           ip;
  logic                    cc_v;
  logic [CB-1:0]           cc_code;
  logic [KV_W-1:0]         disp;
  kac_pkg::out_t           res;

  // Result register
  logic                  out_v_r;
  kac_pkg::out_t         out_r;

  // ---------------- read stage ----------------
  // One item in the angle stage at a time: the next read sees its angle write.
  assign pop     = q_valid && !b_v_r;
  assign q_pop   = pop;
  assign rd_en   = pop && (q_ent.kind != kac_pkg::KIND_SKIP);
  assign rd_addr = KW'(q_ent.knob);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      ang_rd_r  <= ang_mem[rd_addr];
      ang_rdv_r <= ang_vld_r[rd_addr];
      val_rd_r  <= val_mem[rd_addr];
      val_rdv_r <= val_vld_r[rd_addr];
      fwd_hit_r <= wr_en && (wr_addr == rd_addr);
      fwd_r     <= val_wr;
    end
    if (pop) begin
      b_ent_r <= q_ent;
    end
  end

  // ---------------- angle and gain stage ----------------
  assign b_adv  = b_v_r && (!c_v_r || c_adv);
  assign b_addr = KW'(b_ent_r.knob);

  always_comb begin
    last_ang = ang_rdv_r ? ang_rd_r : '0;
    d_raw    = signed'({2'b00, b_ent_r.angle}) - signed'({2'b00, last_ang});
    priority if (d_raw > HALF_TURN) begin
      d_wrap = d_raw - FULL_TURN;
    end else if (d_raw < -HALF_TURN) begin
      d_wrap = d_raw + FULL_TURN;
    end else begin
      d_wrap = d_raw;
    end
    d_abs   = d_wrap[DW-1] ? -d_wrap : d_wrap;
    absd    = d_abs[AB-1:0];
    move_ok = (b_ent_r.kind == kac_pkg::KIND_MOVE) && !(absd < cfg.dead_band);
    ang_we  = b_adv && (move_ok || (b_ent_r.kind == kac_pkg::KIND_HOLD));
    prod    = PROD_W'(absd) * PROD_W'(b_ent_r.gain);
    mag     = MAG_W'((MAG_W'(prod) << kac_pkg::UP_SHIFT) >> kac_pkg::DOWN_SHIFT);
    // Take the value write of the item leaving the value stage this cycle
    fwd_now = wr_en && (wr_addr == b_addr);
    priority if (fwd_now) begin
      val_b = val_wr;
    end else if (fwd_hit_r) begin
      val_b = fwd_r;
    end else if (val_rdv_r) begin
      val_b = val_rd_r;
    end else begin
      val_b = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ang_we) begin
      ang_mem[b_addr] <= b_ent_r.angle;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      c_knob_r   <= b_ent_r.knob;
      c_act_r    <= move_ok;
      c_mode_r   <= b_ent_r.mode;
      c_detent_r <= b_ent_r.detent;
      c_neg_r    <= d_wrap[DW-1];
      c_mag_r    <= mag;
      c_val_r    <= val_b;
    end
  end

  // ---------------- value stage ----------------
  assign c_adv   = c_v_r && (!out_v_r || out_ready);
  assign wr_en   = c_adv && c_act_r;
  assign wr_addr = KW'(c_knob_r);

  always_comb begin
    kv_s    = signed'({{(SUM_W - KV_W){1'b0}}, c_val_r.kv});
    mag_s   = signed'({{(SUM_W - MAG_W){1'b0}}, c_mag_r});
    sc_s    = c_neg_r ? -mag_s : mag_s;
    vs      = kv_s + sc_s;
    acc_s   = {{(SUM_W - ACC_W){c_val_r.acc[ACC_W-1]}}, c_val_r.acc};
    acc_sum = acc_s + sc_s;
    acc_neg = acc_sum[SUM_W-1];
    acc_mag = acc_neg ? unsigned'(-acc_sum) : unsigned'(acc_sum);
    stepm   = acc_mag[SUM_W-1:FB];
    rem     = acc_mag[FB-1:0];
    acc_new = acc_neg ? -signed'({1'b0, rem}) : signed'({1'b0, rem});
    gt64    = stepm > STEP_W'(64);
    gt63    = stepm > STEP_W'(63);
    s7      = stepm[CB-1:0];

    // absolute mode: clamp, then snap inside the detent window
    priority if (vs[SUM_W-1]) begin
      v_abs = '0;
    end else if (vs > MAX_V) begin
      v_abs = MAX_V[KV_W-1:0];
    end else begin
      v_abs = vs[KV_W-1:0];
    end
    ip = v_abs[KV_W-1:FB];
    if (c_detent_r && (ip >= cfg.detent_low) && (ip <= cfg.detent_high)) begin
      v_abs = CENTER_V;
      ip    = 7'd64;
    end

    val_wr  = c_val_r;
    cc_code = '0;
    cc_v    = 1'b0;
    if (c_mode_r == kac_pkg::MODE_ABS) begin
      val_wr.kv   = v_abs;
      val_wr.sent = ip;
      disp        = v_abs;
      cc_v        = (ip != c_val_r.sent);
      cc_code     = ip;
    end else begin
      val_wr.kv  = vs[KV_W-1:0];
      val_wr.acc = acc_new;
      disp       = vs[KV_W-1:0];
      unique case (c_mode_r)
        kac_pkg::MODE_REL_TWOS: begin
          cc_v = (stepm != '0);
          if (!acc_neg) begin
            cc_code = gt64 ? 7'd64 : s7;
          end else begin
            cc_code = gt63 ? 7'd65 : CB'(8'd128 - {1'b0, s7});
          end
        end
        kac_pkg::MODE_REL_OFFSET: begin
          cc_v = (stepm != '0);
          if (!acc_neg) begin
            cc_code = gt63 ? 7'd127 : CB'(8'd64 + {1'b0, s7});
          end else begin
            cc_code = gt64 ? 7'd0 : CB'(8'd64 - {1'b0, s7});
          end
        end
        default: begin
          // unused mode: state still moves, no message
          cc_v    = 1'b0;
          cc_code = '0;
        end
      endcase
    end

    res.out_knob      = c_knob_r;
    res.cc_valid      = c_act_r && cc_v;
    res.cc_value      = (c_act_r && cc_v) ? cc_code : '0;
    res.display_valid = c_act_r;
    res.display_value = c_act_r ? kac_pkg::DISP_BITS'(disp) : '0;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      val_mem[wr_addr] <= val_wr;
    end
    if (c_adv) begin
      out_r <= res;
    end
  end

  // ---------------- control ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r     <= 1'b0;
      c_v_r     <= 1'b0;
      out_v_r   <= 1'b0;
      ang_vld_r <= '0;
      val_vld_r <= '0;
    end else begin
      b_v_r   <= pop || (b_v_r && !b_adv);
      c_v_r   <= b_adv || (c_v_r && !c_adv);
      out_v_r <= c_adv || (out_v_r && !out_ready);
      if (ang_we) begin
        ang_vld_r[b_addr] <= 1'b1;
      end
      if (wr_en) begin
        val_vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

FILE: design/knob_angle_to_midi_cc_core.sv
// Top level: configuration registers, front end, queue and back end.
//
// Turns absolute knob angle samples into controller change values. Each
// input transaction yields exactly one result transaction. The back end
// takes no new item until the last has left the angle stage: the per-knob
// angle store is read when an item is popped and written as it leaves; the
// next item's read waits for that write. The front end takes one item per
// cycle while the queue has room, so bursts are absorbed. A result is
// registered in the front end, queue, read stage, value stage and result
// register. Per-knob state starts at zero after reset through valid bits;
// there is no clearing pass. Write configuration only while idle.
`timescale 1ns / 1ps
`default_nettype none
module knob_angle_to_midi_cc_core #(
  parameter int NUM_KNOBS = 20
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire kac_pkg::in_t                         in_data,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output kac_pkg::out_t                             out_data,
  input  wire logic                                 cfg_we,
  input  wire logic [kac_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  wire logic [kac_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  kac_pkg::cfg_t   cfg_r;
  kac_pkg::cfg_t   cfg_nxt;
  logic            q_full;
  logic            q_push;
  kac_pkg::q_ent_t push_ent;
  logic            q_pop;
  logic            q_valid;
  kac_pkg::q_ent_t q_ent;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        kac_pkg::CFG_GAIN_NORMAL: cfg_nxt.gain_normal = cfg_data;
        kac_pkg::CFG_GAIN_DETENT: cfg_nxt.gain_detent = cfg_data;
        kac_pkg::CFG_DEAD_BAND:   cfg_nxt.dead_band   = cfg_data[kac_pkg::DEAD_BITS-1:0];
        kac_pkg::CFG_DETENT_LOW:  cfg_nxt.detent_low  = cfg_data[kac_pkg::CC_BITS-1:0];
        kac_pkg::CFG_DETENT_HIGH: cfg_nxt.detent_high = cfg_data[kac_pkg::CC_BITS-1:0];
        default: cfg_nxt = cfg_r;  // drop writes to unknown indexes
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_normal <= kac_pkg::RST_GAIN_NORMAL;
      cfg_r.gain_detent <= kac_pkg::RST_GAIN_DETENT;
      cfg_r.dead_band   <= kac_pkg::RST_DEAD_BAND;
      cfg_r.detent_low  <= kac_pkg::RST_DETENT_LOW;
      cfg_r.detent_high <= kac_pkg::RST_DETENT_HIGH;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  kac_front #(
    .NUM_KNOBS (NUM_KNOBS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_ent    (push_ent)
  );

  kac_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_ent (push_ent),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_ent    (q_ent)
  );

  kac_back #(
    .NUM_KNOBS (NUM_KNOBS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_ent     (q_ent),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for the knob angle to controller change core.
`timescale 1ns / 1ps
module testbench;
  import kac_pkg::*;

  localparam int NUM_KNOBS      = 20;
  localparam int FULL_TURN      = 1 << ANGLE_BITS;
  localparam int HALF_TURN      = 1 << (ANGLE_BITS - 1);
  localparam longint ONE_UNIT   = 64'sd1 << FRAC_BITS;
  localparam int RAND_PER_PHASE = 154;
  localparam int STALL_LIMIT    = 2000;
  localparam int DRAIN_CYCLES   = 20;

  // cc_mode 3 is not named in the package: relative update, no CC sent
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Handshake idling profiles
  localparam int SLOW_RECEIVER = 0;
  localparam int SLOW_SENDER   = 1;
  localparam int NO_IDLE       = 2;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // Predicted per-knob state and register copy
  int     last_ang [NUM_KNOBS];
  longint kval [NUM_KNOBS];
  int     sent_val [NUM_KNOBS];
  longint step_acc [NUM_KNOBS];
  cfg_t   cfg_model;

  int   gen_ang [32];
  in_t  angle_samples_q [$];
  out_t predicted_cc_q [$];
  int   samples_queued = 0;
  int   samples_taken = 0;
  int   error_count = 0;
  int   stall_cycles = 0;
  int   idle_mode = SLOW_RECEIVER;

  knob_angle_to_midi_cc_core #(.NUM_KNOBS(NUM_KNOBS)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic out_t knob_to_cc(input in_t item);
    out_t   r;
    int     k, a, d, absd, lo, hi;
    longint g, mag, scaled, v, acc, steps, code, ip;
    r = '0;
    r.out_knob = item.knob_index;
    k = int'(item.knob_index);
    if (k >= NUM_KNOBS) return r;
    a = int'(item.angle);
    if (item.resync || item.override_hold) begin
      last_ang[k] = a;
      return r;
    end
    d = a - last_ang[k];
    if (d > HALF_TURN) d -= FULL_TURN;
    else if (d < -HALF_TURN) d += FULL_TURN;
    absd = (d < 0) ? -d : d;
    if (absd < int'(cfg_model.dead_band)) return r;
    last_ang[k] = a;
    g = longint'(item.center_detent ? cfg_model.gain_detent : cfg_model.gain_normal);
    mag = ((absd * g) << UP_SHIFT) >> DOWN_SHIFT;
    scaled = (d < 0) ? -mag : mag;
    if (item.cc_mode == MODE_ABS) begin
      v = kval[k] + scaled;
      if (v < 0) v = 0;
      if (v > 127 * ONE_UNIT) v = 127 * ONE_UNIT;
      ip = v >>> FRAC_BITS;
      lo = int'(cfg_model.detent_low);
      hi = int'(cfg_model.detent_high);
      // snap to center inside the detent window
      if (item.center_detent && ip >= lo && ip <= hi) begin
        ip = 64;
        v = 64 * ONE_UNIT;
      end
      kval[k] = v;
      if (ip != sent_val[k]) begin
        sent_val[k] = int'(ip);
        r.cc_valid = 1'b1;
        r.cc_value = ip[CC_BITS-1:0];
      end
    end else begin
      acc = step_acc[k] + scaled;
      steps = acc / ONE_UNIT;
      if (steps != 0) begin
        acc -= steps * ONE_UNIT;
        code = -1;
        if (item.cc_mode == MODE_REL_TWOS) begin
          if (steps > 0) code = (steps > 64) ? 64 : steps;
          else code = 128 + ((steps < -63) ? -63 : steps);
        end else if (item.cc_mode == MODE_REL_OFFSET) begin
          code = 64 + steps;
          if (code < 0) code = 0;
          if (code > 127) code = 127;
        end
        if (code >= 0) begin
          r.cc_valid = 1'b1;
          r.cc_value = code[CC_BITS-1:0];
        end
      end
      step_acc[k] = acc;
      v = (kval[k] + scaled) & (128 * ONE_UNIT - 1);
      kval[k] = v;
    end
    r.display_valid = 1'b1;
    r.display_value = v[DISP_BITS-1:0];
    return r;
  endfunction

  function automatic bit sender_idles();
    case (idle_mode)
      SLOW_RECEIVER: return $urandom_range(0, 99) < 14;
      SLOW_SENDER:   return $urandom_range(0, 99) < 75;
      default:       return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (idle_mode)
      SLOW_RECEIVER: return $urandom_range(0, 99) < 75;
      SLOW_SENDER:   return $urandom_range(0, 99) < 14;
      default:       return 1'b0;
    endcase
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  // Driver: predict each accepted transaction, then refill the slot
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predicted_cc_q.push_back(knob_to_cc(in_data));
        samples_taken++;
      end
      if (!in_valid || in_ready) begin
        if (angle_samples_q.size() != 0 && !sender_idles()) begin
          in_valid <= 1'b1;
          in_data <= angle_samples_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_cc_q.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
        end else begin
          want = predicted_cc_q.pop_front();
          check_field("out_knob", 32'(want.out_knob), 32'(out_data.out_knob));
          check_field("cc_valid", 32'(want.cc_valid), 32'(out_data.cc_valid));
          check_field("cc_value", 32'(want.cc_value), 32'(out_data.cc_value));
          check_field("display_valid", 32'(want.display_valid),
                      32'(out_data.display_valid));
          check_field("display_value", 32'(want.display_value),
                      32'(out_data.display_value));
        end
      end
      out_ready <= !receiver_stalls();
    end
  end

  // Watchdog: count cycles with work outstanding and no transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (samples_queued == samples_taken && predicted_cc_q.size() == 0))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic queue_item(input int knob, input int ang, input bit rs, input bit ho,
                            input logic [1:0] mode, input bit det);
    in_t it;
    it.knob_index = knob[KNOB_BITS-1:0];
    it.angle = ang[ANGLE_BITS-1:0];
    it.resync = rs;
    it.override_hold = ho;
    it.cc_mode = mode;
    it.center_detent = det;
    gen_ang[knob[KNOB_BITS-1:0]] = ang & (FULL_TURN - 1);
    angle_samples_q.push_back(it);
    samples_queued++;
  endtask

  task automatic queue_random(input int count);
    int k, delta, pick, ang;
    logic [1:0] mode;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      k = (pick < 5) ? $urandom_range(20, 31) : $urandom_range(0, NUM_KNOBS - 1);
      // mostly turns from where the knob sits, sometimes a jump anywhere
      pick = $urandom_range(0, 99);
      if (pick < 45) delta = $urandom_range(0, 24) - 12;
      else if (pick < 80) delta = $urandom_range(0, 800) - 400;
      else if (pick < 90) delta = ($urandom_range(0, 1) ? 2048 : -2048) + $urandom_range(0, 1);
      else delta = $urandom_range(0, FULL_TURN - 1);
      ang = (gen_ang[k] + delta) & (FULL_TURN - 1);
      pick = $urandom_range(0, 99);
      if (pick < 40) mode = MODE_ABS;
      else if (pick < 65) mode = MODE_REL_TWOS;
      else if (pick < 90) mode = MODE_REL_OFFSET;
      else mode = MODE_UNUSED;
      queue_item(k, ang, $urandom_range(0, 99) < 5, $urandom_range(0, 99) < 5, mode,
                 $urandom_range(0, 99) < 40);
    end
  endtask

  task automatic wait_drained();
    while (samples_queued != samples_taken || predicted_cc_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_GAIN_NORMAL: cfg_model.gain_normal = val;
      CFG_GAIN_DETENT: cfg_model.gain_detent = val;
      CFG_DEAD_BAND:   cfg_model.dead_band = val[DEAD_BITS-1:0];
      CFG_DETENT_LOW:  cfg_model.detent_low = val[CC_BITS-1:0];
      CFG_DETENT_HIGH: cfg_model.detent_high = val[CC_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input cfg_t c);
    write_reg(CFG_GAIN_NORMAL, c.gain_normal);
    write_reg(CFG_GAIN_DETENT, c.gain_detent);
    write_reg(CFG_DEAD_BAND, CFG_DATA_BITS'(c.dead_band));
    write_reg(CFG_DETENT_LOW, CFG_DATA_BITS'(c.detent_low));
    write_reg(CFG_DETENT_HIGH, CFG_DATA_BITS'(c.detent_high));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    cfg_t phase_cfg [6];
    int p, k;
    for (k = 0; k < NUM_KNOBS; k++) begin
      last_ang[k] = 0;
      kval[k] = 0;
      sent_val[k] = 0;
      step_acc[k] = 0;
    end
    for (k = 0; k < 32; k++) gen_ang[k] = 0;
    cfg_model.gain_normal = RST_GAIN_NORMAL;
    cfg_model.gain_detent = RST_GAIN_DETENT;
    cfg_model.dead_band = RST_DEAD_BAND;
    cfg_model.detent_low = RST_DETENT_LOW;
    cfg_model.detent_high = RST_DETENT_HIGH;

    phase_cfg[0] = cfg_model;
    phase_cfg[1] = {16'hFFFF, 16'hFFFF, 12'd0, 7'd0, 7'd127};
    // dead band at a half turn, empty detent window
    phase_cfg[2] = {16'd0, 16'd0, 12'd2048, 7'd127, 7'd0};
    phase_cfg[3] = {16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                    12'($urandom_range(0, 15)), 7'($urandom_range(0, 64)),
                    7'($urandom_range(64, 127))};
    phase_cfg[4] = {16'd1, 16'd1, 12'd4095, 7'd64, 7'd64};
    phase_cfg[5] = {16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                    12'($urandom_range(0, 8)), 7'($urandom_range(50, 64)),
                    7'($urandom_range(64, 80))};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under reset register values
    queue_item(0, 2, 0, 0, MODE_ABS, 0);          // under dead band
    queue_item(0, 3, 0, 0, MODE_ABS, 0);          // at dead band
    queue_item(0, 2051, 0, 0, MODE_ABS, 0);       // exactly half turn up
    queue_item(0, 3, 0, 0, MODE_ABS, 0);          // exactly half turn down
    queue_item(0, 2052, 0, 0, MODE_ABS, 0);       // past half turn wraps down, clamp low
    queue_item(1, 2000, 0, 0, MODE_ABS, 0);
    queue_item(1, 4000, 0, 0, MODE_ABS, 0);
    queue_item(1, 1904, 0, 0, MODE_ABS, 0);       // wraps forward, clamp high
    queue_item(2, 2000, 0, 0, MODE_ABS, 1);
    queue_item(2, 4000, 0, 0, MODE_ABS, 1);
    queue_item(2, 904, 0, 0, MODE_ABS, 1);        // lands in detent window
    queue_item(20, 4095, 0, 0, MODE_ABS, 1);      // knob out of range
    queue_item(31, 4095, 1, 1, MODE_UNUSED, 1);
    queue_item(3, 1000, 1, 0, MODE_REL_TWOS, 0);  // resync
    queue_item(3, 1010, 0, 0, MODE_REL_TWOS, 0);  // fraction only
    queue_item(3, 3000, 0, 1, MODE_REL_TWOS, 0);  // override hold
    queue_item(3, 952, 0, 0, MODE_REL_TWOS, 0);   // large negative step
    queue_item(4, 2048, 0, 0, MODE_REL_TWOS, 0);
    queue_item(5, 2048, 0, 0, MODE_REL_OFFSET, 0);
    queue_item(5, 0, 0, 0, MODE_REL_OFFSET, 0);
    queue_item(6, 2048, 0, 0, MODE_UNUSED, 0);
    queue_item(6, 0, 0, 0, MODE_UNUSED, 0);
    queue_item(6, 4000, 0, 0, MODE_UNUSED, 0);    // display wraps below zero
    queue_item(19, 4095, 1, 1, MODE_ABS, 1);
    queue_item(19, 0, 0, 0, MODE_ABS, 1);         // one count across zero

    for (p = 0; p < 6; p++) begin
      if (p != 0) begin
        wait_drained();
        if (p == 2) idle_mode = SLOW_SENDER;
        else if (p == 4) idle_mode = NO_IDLE;
        apply_config(phase_cfg[p]);
      end
      queue_random(RAND_PER_PHASE / 2);
      // hold the sender until every result is back
      wait_drained();
      queue_random(RAND_PER_PHASE - RAND_PER_PHASE / 2);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
